/* rtl/tss_pkg.sv */
// ----------------------------------------------------------------------------
// tss_pkg
// shared types and constants for the three stacks shared store core
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int DEF_STACK_DEPTH = 128;
    localparam int DEF_NUM_STACKS  = 3;

    localparam int REQ_W = 2;
    localparam int SEL_W = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

/* rtl/tss_ram.sv */
// ----------------------------------------------------------------------------
// tss_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tss_ctrl.sv */
// ----------------------------------------------------------------------------
// tss_ctrl
// request sequencer: capture, execute, hand result to output register
// ----------------------------------------------------------------------------
module tss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tss_pkg::t_stat i_stat,
    output tss_pkg::t_cmd  o_cmd
);

    tss_pkg::t_state r_state;
    tss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_ready       = 1'b0;
        unique case (r_state)
            tss_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = tss_pkg::S_EXEC;
                end
            end
            tss_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = tss_pkg::S_DONE;
            end
            tss_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = tss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tss_dp.sv */
// ----------------------------------------------------------------------------
// tss_dp
// datapath: request registers, fill counters, store access, output register
// ----------------------------------------------------------------------------
module tss_dp #(
    parameter int STACK_DEPTH = tss_pkg::DEF_STACK_DEPTH,
    parameter int NUM_STACKS  = tss_pkg::DEF_NUM_STACKS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tss_pkg::t_cmd              i_cmd,
    output tss_pkg::t_stat             o_stat,
    input  logic [tss_pkg::REQ_W-1:0]  i_req_type,
    input  logic [tss_pkg::SEL_W-1:0]  i_stack_sel,
    input  logic [tss_pkg::VAL_W-1:0]  i_push_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [tss_pkg::VAL_W-1:0]  o_read_value,
    output logic [tss_pkg::ST_W-1:0]   o_status,
    output logic                       o_now_empty
);

    localparam int DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(STACK_DEPTH + 1);
    localparam int SW    = $clog2(NUM_STACKS);

    logic [tss_pkg::REQ_W-1:0] r_req;
    logic [tss_pkg::SEL_W-1:0] r_sel;
    logic [tss_pkg::VAL_W-1:0] r_val;
    logic [FW-1:0]             r_fill [NUM_STACKS];

    logic [tss_pkg::ST_W-1:0]  r_status;
    logic                      r_empty;
    logic                      r_rd_hit;

    logic                      r_out_valid;
    logic [tss_pkg::VAL_W-1:0] r_out_value;
    logic [tss_pkg::ST_W-1:0]  r_out_status;
    logic                      r_out_empty;

    logic [SW+tss_pkg::SEL_W-1:0] w_sel_ext;
    logic [SW-1:0]                w_idx;
    logic                         w_sel_ok;
    logic [FW-1:0]                w_fill;
    logic [FW-1:0]                n_fill;
    logic [tss_pkg::ST_W-1:0]     n_status;
    logic                         n_rd_hit;
    logic                         w_we;
    logic                         w_re;
    logic [FW-1:0]                w_pos;
    logic [AW-1:0]                w_addr;
    logic [tss_pkg::VAL_W-1:0]    w_rdata;

    assign w_sel_ext = {{SW{1'b0}}, r_sel};
    assign w_idx     = w_sel_ext[SW-1:0];
    assign w_sel_ok  = ({30'd0, r_sel} < 32'(NUM_STACKS));
    assign w_fill    = r_fill[w_idx];

    always_comb begin
        n_fill   = w_fill;
        n_status = tss_pkg::ST_OK;
        n_rd_hit = 1'b0;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_pos    = w_fill;
        if (w_sel_ok) begin
            if (r_req == tss_pkg::REQ_PUSH) begin
                if (w_fill == FW'(STACK_DEPTH)) begin
                    n_status = tss_pkg::ST_FULL;
                end else begin
                    w_we   = i_cmd.exec;
                    n_fill = w_fill + FW'(1);
                end
            end else if (r_req == tss_pkg::REQ_POP || r_req == tss_pkg::REQ_PEEK) begin
                if (w_fill == '0) begin
                    n_status = tss_pkg::ST_EMPTY;
                end else begin
                    w_pos    = w_fill - FW'(1);
                    w_re     = i_cmd.exec;
                    n_rd_hit = 1'b1;
                    if (r_req == tss_pkg::REQ_POP) begin
                        n_fill = w_fill - FW'(1);
                    end
                end
            end
        end
    end

    assign w_addr = AW'(w_idx) * AW'(STACK_DEPTH) + AW'(w_pos);

    tss_ram #(
        .WIDTH (tss_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (r_val),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req_type;
            r_sel <= i_stack_sel;
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rd_hit <= n_rd_hit;
            r_empty  <= w_sel_ok ? (n_fill == '0) : 1'b1;
        end
        if (i_cmd.load) begin
            r_out_value  <= r_rd_hit ? w_rdata : '0;
            r_out_status <= r_status;
            r_out_empty  <= r_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_fill[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec && w_sel_ok) begin
                r_fill[w_idx] <= n_fill;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_read_value    = r_out_value;
    assign o_status        = r_out_status;
    assign o_now_empty     = r_out_empty;

endmodule

/* rtl/three_stacks_shared_store_core.sv */
// ----------------------------------------------------------------------------
// three_stacks_shared_store_core
// lifo stacks in fixed partitions of one shared single port store
// ----------------------------------------------------------------------------
// the result beat is registered at the result load step, after capture and store access
// requests are taken one at a time: a new one is accepted only after the result load
// an unaccepted result holds the sequencer in its load step
// reset: synchronous; clears all fill counts (stacks empty) and control state,
// the store itself is not cleared and needs no clearing pass
module three_stacks_shared_store_core #(
    parameter int STACK_DEPTH = tss_pkg::DEF_STACK_DEPTH,
    parameter int NUM_STACKS  = tss_pkg::DEF_NUM_STACKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // push_value
    input  logic [3:0]  i_s_axis_tuser,  // req_type, stack_sel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // read_value
    output logic [2:0]  o_m_axis_tuser   // status, now_empty
);

    tss_pkg::t_cmd  w_cmd;
    tss_pkg::t_stat w_stat;
    logic [tss_pkg::ST_W-1:0] w_status;
    logic                     w_now_empty;

    tss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    tss_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_STACKS  (NUM_STACKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_req_type   (i_s_axis_tuser[1:0]),
        .i_stack_sel  (i_s_axis_tuser[3:2]),
        .i_push_value (i_s_axis_tdata),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_read_value (o_m_axis_tdata),
        .o_status     (w_status),
        .o_now_empty  (w_now_empty)
    );

    assign o_m_axis_tuser = {w_now_empty, w_status};

endmodule

/* tb/sv/tb_three_stacks_shared_store_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_stacks_shared_store_core
// self-checking bench for the three stacks shared store core
// ----------------------------------------------------------------------------
// local model of fill counts and partitions predicts each result beat
// directed extremes, error and ignored cases, one stack filled and drained
// random push or pop biased phases, long receiver stall
// ----------------------------------------------------------------------------
module tb_three_stacks_shared_store_core;
    import tss_pkg::*;

    localparam int DEPTH  = DEF_STACK_DEPTH;
    localparam int NSTK   = DEF_NUM_STACKS;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
    localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [ST_W-1:0]  status;
        logic             now_empty;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // push_value
    logic [3:0]  i_s_axis_tuser;   // req_type, stack_sel
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // read_value
    logic [2:0]  o_m_axis_tuser;   // status, now_empty

    logic [VAL_W-1:0] part_mem [NSTK*DEPTH];
    int               fill_cnt [NSTK];
    t_result          pending_results[$];

    int  err_cnt;
    int  beats_in;
    int  beats_out;
    int  full_hits;
    int  empty_hits;
    int  rx_hold_req;
    bit  no_idle;

    three_stacks_shared_store_core #(
        .STACK_DEPTH (DEPTH),
        .NUM_STACKS  (NSTK)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("run timed out with %0d results outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_result stack_predict(input logic [REQ_W-1:0] req,
                                              input logic [SEL_W-1:0] sel,
                                              input logic [VAL_W-1:0] val);
        t_result r;
        int      f;
        r.read_value = '0;
        r.status     = ST_OK;
        r.now_empty  = 1'b1;
        if (sel < NSTK) begin
            f = fill_cnt[sel];
            if (req == REQ_PUSH) begin
                if (f >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    part_mem[sel*DEPTH + f] = val;
                    f++;
                end
            end else if (req == REQ_POP || req == REQ_PEEK) begin
                if (f == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = part_mem[sel*DEPTH + f - 1];
                    if (req == REQ_POP) f--;
                end
            end
            fill_cnt[sel] = f;
            r.now_empty   = (f == 0);
        end
        return r;
    endfunction

    task automatic send_req(input logic [REQ_W-1:0] req, input logic [SEL_W-1:0] sel,
                            input logic [VAL_W-1:0] val);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 8) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= val;
        i_s_axis_tuser  <= {sel, req};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(stack_predict(req, sel, val));
        beats_in++;
    endtask

    // receiver: random idling, or a long counted hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else if (no_idle) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= 8);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            beats_out++;
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding: data %h user %b",
                       o_m_axis_tdata, o_m_axis_tuser);
                err_cnt++;
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r.status == ST_FULL)  full_hits++;
                if (exp_r.status == ST_EMPTY) empty_hits++;
                if (o_m_axis_tdata !== exp_r.read_value) begin
                    $error("read_value expected %h actual %h", exp_r.read_value,
                           o_m_axis_tdata);
                    err_cnt++;
                end
                if (o_m_axis_tuser[1:0] !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status,
                           o_m_axis_tuser[1:0]);
                    err_cnt++;
                end
                if (o_m_axis_tuser[2] !== exp_r.now_empty) begin
                    $error("now_empty expected %b actual %b", exp_r.now_empty,
                           o_m_axis_tuser[2]);
                    err_cnt++;
                end
            end
        end
    end

    task automatic test_directed();
        send_req(REQ_PEEK, 2'd0, 32'h0);
        send_req(REQ_POP,  2'd0, 32'hFFFF_FFFF);
        send_req(REQ_POP,  2'd1, 32'h0);
        send_req(REQ_PEEK, 2'd2, 32'h0);
        send_req(REQ_PUSH, 2'd0, 32'h7FFF_FFFF);
        send_req(REQ_PUSH, 2'd0, 32'h8000_0000);
        send_req(REQ_PUSH, 2'd0, 32'h0);
        send_req(REQ_PUSH, 2'd0, 32'hFFFF_FFFF);
        send_req(REQ_PEEK, 2'd0, 32'h5555_5555);
        send_req(REQ_PUSH, 2'd1, 32'd100);
        send_req(REQ_PUSH, 2'd2, 32'hFFFF_FFFF);
        send_req(REQ_NONE, 2'd1, 32'hAAAA_AAAA);
        send_req(REQ_NONE, 2'd0, 32'h1234_5678);
        send_req(REQ_PUSH, SEL_NONE, 32'hDEAD_BEEF);
        send_req(REQ_POP,  SEL_NONE, 32'h0);
        send_req(REQ_PEEK, SEL_NONE, 32'h0);
        send_req(REQ_NONE, SEL_NONE, 32'hFFFF_FFFF);
        for (int i = 0; i < 5; i++) send_req(REQ_POP, 2'd0, 32'h0);
        send_req(REQ_POP,  2'd1, 32'h0);
        send_req(REQ_PEEK, 2'd2, 32'h0);
        send_req(REQ_POP,  2'd2, 32'h0);
    endtask

    task automatic test_fill_to_full();
        logic [SEL_W-1:0] s;
        s = SEL_W'($urandom_range(NSTK-1));
        for (int i = 0; i < DEPTH; i++) send_req(REQ_PUSH, s, $urandom);
        send_req(REQ_PUSH, s, $urandom);
        send_req(REQ_PUSH, s, $urandom);
        send_req(REQ_PEEK, s, $urandom);
        for (int i = 0; i <= DEPTH; i++) send_req(REQ_POP, s, $urandom);
    endtask

    // push_pct sets the drift: high values fill stacks, low values drain them
    task automatic test_random_phase(input int n, input int push_pct);
        logic [REQ_W-1:0] req;
        logic [SEL_W-1:0] sel;
        logic [SEL_W-1:0] fav;
        int               roll;
        fav = SEL_W'($urandom_range(NSTK-1));
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < push_pct) req = REQ_PUSH;
            else if (roll < push_pct + (100 - push_pct) * 2 / 3) req = REQ_POP;
            else req = REQ_PEEK;
            sel = ($urandom_range(99) < 70) ? fav : SEL_W'($urandom_range(NSTK-1));
            if ($urandom_range(99) < 5) begin
                if ($urandom_range(1) != 0) req = REQ_NONE;
                else sel = SEL_NONE;
            end
            send_req(req, sel, $urandom);
        end
    endtask

    task automatic test_output_stall();
        rx_hold_req = 300;
        for (int i = 0; i < 40; i++)
            send_req(REQ_W'($urandom_range(2)), SEL_W'($urandom_range(NSTK-1)), $urandom);
    endtask

    initial begin
        err_cnt     = 0;
        beats_in    = 0;
        beats_out   = 0;
        full_hits   = 0;
        empty_hits  = 0;
        rx_hold_req = 0;
        no_idle     = 1'b0;
        for (int s = 0; s < NSTK; s++) fill_cnt[s] = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_to_full();
        test_random_phase(150, 85);
        test_random_phase(150, 15);
        test_output_stall();
        test_random_phase(150, 50);
        no_idle = 1'b1;
        test_random_phase(150, 85);
        no_idle = 1'b0;
        test_random_phase(150, 50);
        test_random_phase(150, 15);

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests and %0d results across extremes, ignored codes,",
                 beats_in, beats_out);
        $display("%0d full-stack pushes, %0d empty-stack reads and a long output stall",
                 full_hits, empty_hits);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d field mismatches", err_cnt);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
